@@ rtl/wfbrop_pkg.sv @@
package wfbrop_pkg;

  // Largest frame side in pixels; the frame store holds MAX_DIM * MAX_DIM bytes.
  localparam int MAX_DIM     = 256;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  // Wide enough to hold MAX_DIM itself.
  localparam int DIM_W       = $clog2(MAX_DIM + 1);

  // Field widths.
  localparam int CFG_W      = 9;
  localparam int ROP_W      = 3;
  localparam int IDX_W      = 3;
  localparam int OFFSET_W   = 16;
  localparam int PIX_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int AREA_W     = 2 * CFG_W;
  localparam int ROW_W      = OFFSET_W + 1;
  localparam int COL_W      = CFG_W + 1;
  localparam int DIV_STEPS  = OFFSET_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [PIX_W-1:0] PIX_MAX    = 8'hFF;
  localparam logic [PIX_W-1:0] RESET_BYTE = 8'h30;

  // Access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BEYOND  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_FB_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FB_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_WIN_X     = 3'd2;
  localparam logic [IDX_W-1:0] REG_WIN_Y     = 3'd3;
  localparam logic [IDX_W-1:0] REG_WIN_W     = 3'd4;
  localparam logic [IDX_W-1:0] REG_WIN_H     = 3'd5;
  localparam logic [IDX_W-1:0] REG_RASTER_OP = 3'd6;

  // Raster operation codes; the two unused codes behave as set.
  localparam logic [ROP_W-1:0] ROP_SET = 3'd0;
  localparam logic [ROP_W-1:0] ROP_ADD = 3'd1;
  localparam logic [ROP_W-1:0] ROP_SUB = 3'd2;
  localparam logic [ROP_W-1:0] ROP_AND = 3'd3;
  localparam logic [ROP_W-1:0] ROP_OR  = 3'd4;
  localparam logic [ROP_W-1:0] ROP_XOR = 3'd5;

  // Divider request and response.
  typedef struct packed {
    logic                start;
    logic [OFFSET_W-1:0] dividend;
    logic [CFG_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [OFFSET_W-1:0] quo;
    logic [CFG_W-1:0]    rem;
  } div_rsp_t;

  // Frame store access.
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } store_req_t;

endpackage

@@ rtl/wfbrop_if.sv @@
// Access request channel.
interface wfbrop_in_if import wfbrop_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [OFFSET_W-1:0] offset;
  logic [PIX_W-1:0]    data_in;

  modport source(output valid, operation, offset, data_in, input ready);
  modport sink(input valid, operation, offset, data_in, output ready);
endinterface

// Result channel.
interface wfbrop_out_if import wfbrop_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PIX_W-1:0]    read_data;
  logic [STATUS_W-1:0] status;

  modport source(output valid, read_data, status, input ready);
  modport sink(input valid, read_data, status, output ready);
endinterface

// Configuration write channel.
interface wfbrop_cfg_if import wfbrop_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/wfbrop_div.sv @@
// Restoring divider: one quotient bit per cycle.
module wfbrop_div import wfbrop_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [OFFSET_W-1:0]  quo_r;
  logic [CFG_W-1:0]     rem_r;
  logic [CFG_W-1:0]     dvs_r;

  logic [CFG_W:0]       rem_shift;
  logic [CFG_W:0]       rem_diff;
  logic                 fits;

  // One trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    rem_shift = {rem_r, quo_r[OFFSET_W-1]};
    rem_diff  = rem_shift - {1'b0, dvs_r};
    fits      = (rem_shift >= {1'b0, dvs_r});
  end

  // Control: busy while the quotient bits shift in, then a single-cycle done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient shifts in where the dividend shifts out.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[OFFSET_W-2:0], fits};
      rem_r <= fits ? rem_diff[CFG_W-1:0] : rem_shift[CFG_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

@@ rtl/wfbrop_store.sv @@
// Frame store: one write and one read per cycle, registered read data.
// After reset every byte is swept to RESET_BYTE, one address per cycle.
module wfbrop_store import wfbrop_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  store_req_t       req,
  output logic [PIX_W-1:0] rd_data,
  output logic             clear_done
);

  logic [PIX_W-1:0]  mem [STORE_DEPTH];
  logic [PIX_W-1:0]  rd_data_r;
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [PIX_W-1:0]  wr_data;

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // The sweep owns the write port until it finishes.
  always_comb begin
    wr_en   = clr_busy_r | req.wr_en;
    wr_addr = clr_busy_r ? clr_addr_r : req.addr;
    wr_data = clr_busy_r ? RESET_BYTE : req.wdata;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data    = rd_data_r;
  assign clear_done = !clr_busy_r;

endmodule

@@ rtl/windowed_framebuffer_raster_op.sv @@
// Windowed frame store with raster-operation writes.
// Requests arrive on in_chan (operation, offset, data_in) and each gives one
// result on out_chan (read_data, status). Register writes arrive on cfg_chan,
// which is always ready; write it only while no request is in flight.
// A request is taken only while the block is idle, and the unit works on one
// request at a time. An access inside the frame runs through the area
// multiply, the range check, the restoring divide that splits the offset into
// window row and column, the frame check, the address multiply and the
// read-modify-write on the single-port frame store; a pixel outside the frame
// stops after the frame check, and an offset beyond the window after the range
// check. A new request can be taken in the cycle after the previous result is
// registered.
// A registered result waits for out_chan.ready while the next request is
// accepted and worked on; that request holds at its end until the register
// frees up.
// After reset the frame store is swept to 0x30, one byte per cycle, and
// in_chan.ready stays low until the sweep ends. Configuration writes are taken
// during the sweep.
module windowed_framebuffer_raster_op import wfbrop_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  wfbrop_cfg_if.sink   cfg_chan,
  wfbrop_in_if.sink    in_chan,
  wfbrop_out_if.source out_chan
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_AREA,
    S_CHECK,
    S_DIV,
    S_MAP,
    S_ADDR,
    S_MEM,
    S_RDW,
    S_DONE
  } state_t;

  // Configuration registers.
  logic [CFG_W-1:0] fb_width_r;
  logic [CFG_W-1:0] fb_height_r;
  logic [CFG_W-1:0] win_x_r;
  logic [CFG_W-1:0] win_y_r;
  logic [CFG_W-1:0] win_w_r;
  logic [CFG_W-1:0] win_h_r;
  logic [ROP_W-1:0] raster_op_r;

  // Sequencer and working registers.
  state_t              state_r,   state_nxt;
  logic                op_r,      op_nxt;
  logic [OFFSET_W-1:0] offset_r,  offset_nxt;
  logic [PIX_W-1:0]    data_r,    data_nxt;
  logic [AREA_W-1:0]   area_r,    area_nxt;
  logic [ROW_W-1:0]    frow_r,    frow_nxt;
  logic [COL_W-1:0]    fcol_r,    fcol_nxt;
  logic [ADDR_W-1:0]   addr_r,    addr_nxt;
  logic [PIX_W-1:0]    res_data_r,   res_data_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;

  // Output register.
  logic                out_valid_r,  out_valid_nxt;
  logic [PIX_W-1:0]    out_data_r,   out_data_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                in_fire;
  logic [DIM_W-1:0]    fw;
  logic [DIM_W-1:0]    fh;
  logic [2*DIM_W-1:0]  prod;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  store_req_t          store_req;
  logic [PIX_W-1:0]    store_rd_data;
  logic                clear_done;

  // Write combine by raster operation; add and subtract saturate as unsigned.
  function automatic logic [PIX_W-1:0] combine(input logic [ROP_W-1:0] op,
                                               input logic [PIX_W-1:0] pix,
                                               input logic [PIX_W-1:0] d);
    logic [PIX_W:0]   sum;
    logic [PIX_W-1:0] r;
    sum = {1'b0, pix} + {1'b0, d};
    case (op)
      ROP_ADD: r = sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
      ROP_SUB: r = (pix < d) ? '0 : pix - d;
      ROP_AND: r = pix & d;
      ROP_OR:  r = pix | d;
      ROP_XOR: r = pix ^ d;
      default: r = d;
    endcase
    return r;
  endfunction

  wfbrop_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  wfbrop_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (store_req),
    .rd_data    (store_rd_data),
    .clear_done (clear_done)
  );

  // Configuration port never stalls.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_width_r  <= CFG_W'(256);
      fb_height_r <= CFG_W'(256);
      win_x_r     <= '0;
      win_y_r     <= '0;
      win_w_r     <= CFG_W'(256);
      win_h_r     <= CFG_W'(256);
      raster_op_r <= ROP_SET;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_FB_WIDTH:  fb_width_r  <= cfg_chan.data;
        REG_FB_HEIGHT: fb_height_r <= cfg_chan.data;
        REG_WIN_X:     win_x_r     <= cfg_chan.data;
        REG_WIN_Y:     win_y_r     <= cfg_chan.data;
        REG_WIN_W:     win_w_r     <= cfg_chan.data;
        REG_WIN_H:     win_h_r     <= cfg_chan.data;
        REG_RASTER_OP: raster_op_r <= cfg_chan.data[ROP_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame size saturated to MAX_DIM.
  always_comb begin
    fw = (32'(fb_width_r)  > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(fb_width_r);
    fh = (32'(fb_height_r) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(fb_height_r);
  end

  // Row times frame width; the row is already known to be below the height.
  assign prod = (2*DIM_W)'(frow_r[DIM_W-1:0]) * (2*DIM_W)'(fw);

  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) && clear_done;

  // Divider and store requests.
  always_comb begin
    div_req.start    = (state_r == S_CHECK) && (AREA_W'(offset_r) < area_r);
    div_req.dividend = offset_r;
    div_req.divisor  = win_w_r;

    store_req.rd_en = (state_r == S_MEM);
    store_req.wr_en = (state_r == S_RDW) && (op_r == OP_WRITE);
    store_req.addr  = addr_r;
    store_req.wdata = combine(raster_op_r, store_rd_data, data_r);
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    offset_nxt     = offset_r;
    data_nxt       = data_r;
    area_nxt       = area_r;
    frow_nxt       = frow_r;
    fcol_nxt       = fcol_r;
    addr_nxt       = addr_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_chan.operation;
          offset_nxt = in_chan.offset;
          data_nxt   = in_chan.data_in;
          state_nxt  = S_AREA;
        end
      end
      S_AREA: begin
        area_nxt  = AREA_W'(win_w_r) * AREA_W'(win_h_r);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // A zero width gives a zero area, so no divide by zero starts.
        if (AREA_W'(offset_r) >= area_r) begin
          res_data_nxt   = '0;
          res_status_nxt = STATUS_BEYOND;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          frow_nxt  = ROW_W'(win_y_r) + ROW_W'(div_rsp.quo);
          fcol_nxt  = COL_W'(win_x_r) + COL_W'(div_rsp.rem);
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        if (frow_r >= ROW_W'(fh) || 32'(fcol_r) >= 32'(fw)) begin
          res_data_nxt   = '0;
          res_status_nxt = STATUS_OUTSIDE;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        // Row below height and column below width keep this inside the store.
        addr_nxt  = ADDR_W'(prod + (2*DIM_W)'(fcol_r));
        state_nxt = S_MEM;
      end
      S_MEM: begin
        state_nxt = S_RDW;
      end
      S_RDW: begin
        res_data_nxt   = (op_r == OP_WRITE) ? '0 : store_rd_data;
        res_status_nxt = STATUS_DONE;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, output register and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    op_r         <= op_nxt;
    offset_r     <= offset_nxt;
    data_r       <= data_nxt;
    area_r       <= area_nxt;
    frow_r       <= frow_nxt;
    fcol_r       <= fcol_nxt;
    addr_r       <= addr_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = out_data_r;
  assign out_chan.status    = out_status_r;

endmodule

@@ rtl/wfbrop_checker.sv @@
// Port-level checks for the windowed frame store.
module wfbrop_checker import wfbrop_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [PIX_W-1:0]    out_read_data,
  input logic [STATUS_W-1:0] out_status
);

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_status))
    else $error("result changed while stalled");

  // One request at a time: the block is busy right after taking one.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a request is in flight");

  // Status is a defined code, and a failed access returns zero data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_DONE) ||
                  ((out_status == STATUS_BEYOND || out_status == STATUS_OUTSIDE) &&
                   out_read_data == '0))
    else $error("bad status or nonzero data on failed access");

  // Reset empties the result register and starts the clearing pass.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

endmodule

bind windowed_framebuffer_raster_op wfbrop_checker u_wfbrop_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_read_data (out_chan.read_data),
  .out_status    (out_chan.status)
);

@@ tb/windowed_framebuffer_raster_op_test.sv @@
`timescale 1ns / 1ps

module windowed_framebuffer_raster_op_test;
  import wfbrop_pkg::*;

  localparam int QUIET_LIMIT    = 300000;
  localparam int HOLD_OFF       = 400;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 120;
  localparam int TAIL_CYCLES    = 40;
  localparam logic [ROP_W-1:0] ROP_SPARE = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel;
    logic [STATUS_W-1:0] status;
  } pixel_reply_t;

  typedef enum logic {ROW_ACCESS, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic                op;
    logic [OFFSET_W-1:0] offset;
    logic [PIX_W-1:0]    data;
    logic [IDX_W-1:0]    index;
    logic [CFG_W-1:0]    value;
    logic                fixed;
    pixel_reply_t        reply;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  wfbrop_cfg_if cfg_chan ();
  wfbrop_in_if  in_chan ();
  wfbrop_out_if out_chan ();

  windowed_framebuffer_raster_op u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow copy of the frame and of the register file.
  logic [PIX_W-1:0] frame_copy [STORE_DEPTH];
  logic [CFG_W-1:0] cur_fb_width, cur_fb_height, cur_win_x, cur_win_y, cur_win_w, cur_win_h;
  logic [ROP_W-1:0] cur_rop;

  pixel_reply_t awaited_replies [$];
  stim_row_t    stim_rows [$];
  pixel_reply_t fixed_reply;
  logic         fixed_on = 1'b0;
  int           mismatches = 0;
  int           replies_seen = 0;
  int           idle_odds = 6;
  bit           held_off = 1'b0;

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Combine a byte into a pixel by the current raster operation.
  function automatic logic [PIX_W-1:0] blend(logic [PIX_W-1:0] pix, logic [PIX_W-1:0] din);
    logic [PIX_W:0] sum;
    sum = {1'b0, pix} + {1'b0, din};
    case (cur_rop)
      ROP_ADD: blend = sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
      ROP_SUB: blend = (pix < din) ? '0 : pix - din;
      ROP_AND: blend = pix & din;
      ROP_OR:  blend = pix | din;
      ROP_XOR: blend = pix ^ din;
      default: blend = din;
    endcase
  endfunction

  // Map one access through the window onto the frame and apply it.
  function automatic pixel_reply_t access_pixel(logic op, logic [OFFSET_W-1:0] off,
                                                logic [PIX_W-1:0] din);
    int unsigned area, fw, fh, row, col, addr;
    pixel_reply_t r;
    area = int'(cur_win_w) * int'(cur_win_h);
    fw = (cur_fb_width > MAX_DIM) ? MAX_DIM : 32'(cur_fb_width);
    fh = (cur_fb_height > MAX_DIM) ? MAX_DIM : 32'(cur_fb_height);
    r.pixel = '0;
    if (cur_win_w == 0 || off >= area) begin
      r.status = STATUS_BEYOND;
    end else begin
      row = 32'(cur_win_y) + 32'(off) / 32'(cur_win_w);
      col = 32'(cur_win_x) + 32'(off) % 32'(cur_win_w);
      if (row >= fh || col >= fw) begin
        r.status = STATUS_OUTSIDE;
      end else begin
        addr = row * fw + col;
        r.status = STATUS_DONE;
        if (op == OP_WRITE) begin
          frame_copy[ADDR_W'(addr)] = blend(frame_copy[ADDR_W'(addr)], din);
        end else begin
          r.pixel = frame_copy[ADDR_W'(addr)];
        end
      end
    end
    return r;
  endfunction

  function automatic void add_access(logic op, logic [OFFSET_W-1:0] off, logic [PIX_W-1:0] din);
    stim_row_t r;
    r.kind   = ROW_ACCESS;
    r.op     = op;
    r.offset = off;
    r.data   = din;
    r.index  = '0;
    r.value  = '0;
    r.fixed  = 1'b0;
    r.reply  = '0;
    stim_rows.push_back(r);
  endfunction

  // Access whose reply is known without the predictor.
  function automatic void add_fixed(logic op, logic [OFFSET_W-1:0] off, logic [PIX_W-1:0] din,
                                    logic [PIX_W-1:0] pix, logic [STATUS_W-1:0] st);
    add_access(op, off, din);
    stim_rows[$].fixed = 1'b1;
    stim_rows[$].reply = '{pixel: pix, status: st};
  endfunction

  function automatic void add_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    stim_row_t r;
    r.kind   = ROW_REG;
    r.op     = OP_READ;
    r.offset = '0;
    r.data   = '0;
    r.index  = idx;
    r.value  = val;
    r.fixed  = 1'b0;
    r.reply  = '0;
    stim_rows.push_back(r);
  endfunction

  // Offer one request, with an optional gap before it, and wait for it to be taken.
  task automatic issue_access(input logic op, input logic [OFFSET_W-1:0] off,
                              input logic [PIX_W-1:0] din);
    if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.offset    <= off;
    in_chan.data_in   <= din;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every reply has come back.
  task automatic drain_replies();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (awaited_replies.size() != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Track register writes, predict each accepted request and check each reply.
  always @(posedge clk) begin
    pixel_reply_t got;
    pixel_reply_t want;
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          REG_FB_WIDTH:  cur_fb_width  = cfg_chan.data;
          REG_FB_HEIGHT: cur_fb_height = cfg_chan.data;
          REG_WIN_X:     cur_win_x     = cfg_chan.data;
          REG_WIN_Y:     cur_win_y     = cfg_chan.data;
          REG_WIN_W:     cur_win_w     = cfg_chan.data;
          REG_WIN_H:     cur_win_h     = cfg_chan.data;
          REG_RASTER_OP: cur_rop       = cfg_chan.data[ROP_W-1:0];
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        got = access_pixel(in_chan.operation, in_chan.offset, in_chan.data_in);
        awaited_replies.push_back(fixed_on ? fixed_reply : got);
      end
      if (out_chan.valid && out_chan.ready) begin
        replies_seen++;
        if (awaited_replies.size() == 0) begin
          $error("unexpected reply: read_data %0h, status %0d", out_chan.read_data,
                 out_chan.status);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_chan.read_data !== want.pixel) begin
            $error("read_data: expected %0h, got %0h", want.pixel, out_chan.read_data);
            mismatches++;
          end
          if (out_chan.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_chan.status);
            mismatches++;
          end
        end
      end
    end
  end

  // Reply side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && replies_seen >= 60) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
        held_off = 1'b1;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Give up when nothing moves on any channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned area, hi, fw, fh, wx, wy, ww, wh;
    logic [ROP_W-1:0]    rop;
    logic                op;
    logic [OFFSET_W-1:0] off;
    logic [PIX_W-1:0]    din;

    // Known values on every input, and the state the block comes out of reset with.
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.operation = OP_READ;
    in_chan.offset    = '0;
    in_chan.data_in   = '0;
    cfg_chan.valid    = 1'b0;
    cfg_chan.index    = REG_FB_WIDTH;
    cfg_chan.data     = '0;
    foreach (frame_copy[i]) frame_copy[i] = RESET_BYTE;
    cur_fb_width  = CFG_W'(MAX_DIM);
    cur_fb_height = CFG_W'(MAX_DIM);
    cur_win_x     = '0;
    cur_win_y     = '0;
    cur_win_w     = CFG_W'(MAX_DIM);
    cur_win_h     = CFG_W'(MAX_DIM);
    cur_rop       = ROP_SET;

    // Directed rows: reset contents, every raster operation, window and frame edges.
    add_fixed(OP_READ, '0, 8'h00, RESET_BYTE, STATUS_DONE);
    add_fixed(OP_READ, 16'hFFFF, 8'hFF, RESET_BYTE, STATUS_DONE);
    add_fixed(OP_WRITE, '0, 8'hFF, 8'h00, STATUS_DONE);
    add_access(OP_READ, '0, 8'h00);
    add_reg(REG_RASTER_OP, CFG_W'(ROP_ADD));
    add_fixed(OP_WRITE, 16'd0, 8'h01, 8'h00, STATUS_DONE);
    add_fixed(OP_WRITE, 16'd1, 8'hFF, 8'h00, STATUS_DONE);
    add_access(OP_READ, 16'd1, 8'h00);
    add_reg(REG_RASTER_OP, CFG_W'(ROP_SUB));
    add_fixed(OP_WRITE, 16'd2, 8'hFF, 8'h00, STATUS_DONE);
    add_access(OP_READ, 16'd2, 8'h00);
    add_reg(REG_RASTER_OP, CFG_W'(ROP_AND));
    add_access(OP_WRITE, 16'd0, 8'h0F);
    add_access(OP_READ, 16'd0, 8'h00);
    add_reg(REG_RASTER_OP, CFG_W'(ROP_OR));
    add_access(OP_WRITE, 16'd3, 8'h81);
    add_reg(REG_RASTER_OP, CFG_W'(ROP_XOR));
    add_access(OP_WRITE, 16'd3, 8'hFF);
    add_access(OP_READ, 16'd3, 8'h00);
    // The spare operation codes behave as a plain set.
    add_reg(REG_RASTER_OP, CFG_W'(ROP_SPARE));
    add_access(OP_WRITE, 16'd4, 8'hA5);
    add_access(OP_READ, 16'd4, 8'h00);
    // A zero window side leaves no area at all.
    add_reg(REG_WIN_W, '0);
    add_fixed(OP_READ, '0, 8'h00, 8'h00, STATUS_BEYOND);
    add_reg(REG_WIN_W, 9'd16);
    add_reg(REG_WIN_H, '0);
    add_fixed(OP_WRITE, '0, 8'h55, 8'h00, STATUS_BEYOND);
    add_reg(REG_WIN_H, 9'd16);
    add_fixed(OP_READ, 16'd256, 8'h00, 8'h00, STATUS_BEYOND);
    add_access(OP_READ, 16'd255, 8'h00);
    // Window hanging over the right edge of the frame.
    add_reg(REG_WIN_X, 9'd250);
    add_fixed(OP_WRITE, 16'd6, 8'h11, 8'h00, STATUS_OUTSIDE);
    add_access(OP_READ, 16'd5, 8'h00);
    add_reg(REG_FB_WIDTH, '0);
    add_fixed(OP_READ, '0, 8'h00, 8'h00, STATUS_OUTSIDE);
    // Oversized frame sides are cut to the largest frame; window over the bottom edge.
    add_reg(REG_FB_WIDTH, 9'h1FF);
    add_reg(REG_FB_HEIGHT, 9'h1FF);
    add_reg(REG_WIN_X, '0);
    add_reg(REG_WIN_Y, 9'd250);
    add_fixed(OP_READ, 16'd96, 8'h00, 8'h00, STATUS_OUTSIDE);
    add_access(OP_READ, 16'd95, 8'h00);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        drain_replies();
        write_reg(stim_rows[i].index, stim_rows[i].value);
      end else begin
        fixed_on    = stim_rows[i].fixed;
        fixed_reply = stim_rows[i].reply;
        issue_access(stim_rows[i].op, stim_rows[i].offset, stim_rows[i].data);
      end
    end
    fixed_on = 1'b0;

    // Random phases, each with its own frame, window and raster operation.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_replies();
      case (phase)
        0: begin
          fw = MAX_DIM; fh = MAX_DIM; wx = 0; wy = 0; ww = MAX_DIM; wh = MAX_DIM;
        end
        1: begin
          fw = MAX_DIM; fh = MAX_DIM; ww = 4; wh = 4;
          wx = $urandom_range(0, 252); wy = $urandom_range(0, 252);
        end
        2: begin
          fw = 20; fh = 24; wx = 15; wy = 18; ww = 10; wh = 10;
        end
        3: begin
          fw = 1; fh = 1; wx = 0; wy = 0; ww = 1; wh = 1;
        end
        4: begin
          fw = 511; fh = 511; wx = 256; wy = 256; ww = 511; wh = 511;
        end
        default: begin
          fw = ($urandom_range(0, 9) == 0) ? $urandom_range(257, 511) : $urandom_range(1, 256);
          fh = ($urandom_range(0, 9) == 0) ? $urandom_range(257, 511) : $urandom_range(1, 256);
          ww = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 16);
          wh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 16);
          wx = $urandom_range(0, fw);
          wy = $urandom_range(0, fh);
        end
      endcase
      rop = ROP_W'(phase % 8);
      write_reg(REG_FB_WIDTH, CFG_W'(fw));
      write_reg(REG_FB_HEIGHT, CFG_W'(fh));
      write_reg(REG_WIN_X, CFG_W'(wx));
      write_reg(REG_WIN_Y, CFG_W'(wy));
      write_reg(REG_WIN_W, CFG_W'(ww));
      write_reg(REG_WIN_H, CFG_W'(wh));
      write_reg(REG_RASTER_OP, CFG_W'(rop));

      // No idling in the last phase; some phases run without gaps as well.
      if (phase == PHASES - 1 || phase % 3 == 1) begin
        idle_odds = 0;
      end else begin
        idle_odds = $urandom_range(3, 12);
      end

      area = ww * wh;
      hi = (area > 65536) ? 65535 : area - 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Mostly offsets inside the window, some at its boundary, some anywhere.
        case ($urandom_range(0, 19)) inside
          [0:14]: begin
            if (area != 0) begin
              off = OFFSET_W'($urandom_range(0, hi));
            end else begin
              off = OFFSET_W'($urandom);
            end
          end
          [15:16]: begin
            case ($urandom_range(0, 3))
              0: off = (area > 65535) ? '1 : OFFSET_W'(area);
              1: off = OFFSET_W'(area - 1);
              2: off = '0;
              default: off = '1;
            endcase
          end
          default: off = OFFSET_W'($urandom);
        endcase
        op = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ;
        case ($urandom_range(0, 7))
          0: din = 8'h00;
          1: din = 8'hFF;
          default: din = PIX_W'($urandom);
        endcase
        issue_access(op, off, din);
      end
    end

    // Let the last replies come back, then allow for anything stray.
    drain_replies();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
